@@ rtl/bqf_pkg.sv @@
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared constants, types, fixed-point helpers and the per-iteration
// microprogram of the quadratic factor refinement engine.
// ----------------------------------------------------------------------------
package bqf_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PCT_W      = 7;
    localparam int PCT_SCALE  = 100;
    localparam int DIV_W      = WORD_WIDTH + PCT_W + FRAC_BITS;
    localparam int RND_W      = 2 * WORD_WIDTH + 1 - FRAC_BITS;
    localparam int MAG_W      = (DIV_W > RND_W) ? DIV_W : RND_W;
    localparam int CFG_IDX_W  = 3;
    localparam int SEL_W      = 5;
    localparam int UC_LEN     = 50;
    localparam int PC_W       = 6;

    typedef logic signed [WORD_WIDTH-1:0] t_word;
    typedef logic [WORD_WIDTH-1:0]        t_uword;

    localparam t_word SMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam t_word SMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam logic [MAG_W-1:0] LIM_POS =
        {{(MAG_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [MAG_W-1:0] LIM_NEG = LIM_POS + MAG_W'(1);
    localparam logic [DIV_W-1:0] WMASK_D =
        {{(DIV_W-WORD_WIDTH){1'b0}}, {WORD_WIDTH{1'b1}}};
    localparam logic [2*WORD_WIDTH:0] RND_HALF =
        (2*WORD_WIDTH+1)'(1) << (FRAC_BITS-1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A5    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITERS = 3'd6;
    localparam logic [7:0]           ITERS_RST = 8'd10;

    // operand / destination codes
    localparam logic [SEL_W-1:0] SEL_ZERO = 5'd0;
    localparam logic [SEL_W-1:0] SEL_R    = 5'd1;
    localparam logic [SEL_W-1:0] SEL_S    = 5'd2;
    localparam logic [SEL_W-1:0] SEL_B0   = 5'd3;
    localparam logic [SEL_W-1:0] SEL_B1   = 5'd4;
    localparam logic [SEL_W-1:0] SEL_B2   = 5'd5;
    localparam logic [SEL_W-1:0] SEL_B3   = 5'd6;
    localparam logic [SEL_W-1:0] SEL_B4   = 5'd7;
    localparam logic [SEL_W-1:0] SEL_B5   = 5'd8;
    localparam logic [SEL_W-1:0] SEL_C1   = 5'd9;
    localparam logic [SEL_W-1:0] SEL_C2   = 5'd10;
    localparam logic [SEL_W-1:0] SEL_C3   = 5'd11;
    localparam logic [SEL_W-1:0] SEL_C4   = 5'd12;
    localparam logic [SEL_W-1:0] SEL_C5   = 5'd13;
    localparam logic [SEL_W-1:0] SEL_A0   = 5'd14;
    localparam logic [SEL_W-1:0] SEL_A1   = 5'd15;
    localparam logic [SEL_W-1:0] SEL_A2   = 5'd16;
    localparam logic [SEL_W-1:0] SEL_A3   = 5'd17;
    localparam logic [SEL_W-1:0] SEL_A4   = 5'd18;
    localparam logic [SEL_W-1:0] SEL_A5   = 5'd19;
    localparam logic [SEL_W-1:0] SEL_DET  = 5'd20;
    localparam logic [SEL_W-1:0] SEL_NR   = 5'd21;
    localparam logic [SEL_W-1:0] SEL_NS   = 5'd22;

    // accumulator operations
    localparam logic [2:0] ACC_NOP  = 3'd0;
    localparam logic [2:0] ACC_LD   = 3'd1;
    localparam logic [2:0] ACC_LDP  = 3'd2;
    localparam logic [2:0] ACC_ADDP = 3'd3;
    localparam logic [2:0] ACC_SUBP = 3'd4;

    // divider jobs
    localparam logic [1:0] DK_DR = 2'd0;
    localparam logic [1:0] DK_DS = 2'd1;
    localparam logic [1:0] DK_PR = 2'd2;
    localparam logic [1:0] DK_PS = 2'd3;

    typedef struct packed {
        logic [SEL_W-1:0] mul_a;
        logic [SEL_W-1:0] mul_b;
        logic [SEL_W-1:0] ld_src;
        logic [2:0]       acc_op;
        logic [SEL_W-1:0] dst;
    } t_uop;

    typedef struct packed {
        logic       load_in;
        t_uop       uop;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_kind;
        logic       update;
        logic       set_sing;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic iter_last;
        logic count_zero;
        logic div_done;
    } t_sts;

    function automatic t_word sat_add(t_word a, t_word b);
        logic [WORD_WIDTH:0] sum;
        sum = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
        if (sum[WORD_WIDTH] != sum[WORD_WIDTH-1]) begin
            return sum[WORD_WIDTH] ? SMIN : SMAX;
        end
        return sum[WORD_WIDTH-1:0];
    endfunction

    function automatic t_word sat_sub(t_word a, t_word b);
        logic [WORD_WIDTH:0] dif;
        dif = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
        if (dif[WORD_WIDTH] != dif[WORD_WIDTH-1]) begin
            return dif[WORD_WIDTH] ? SMIN : SMAX;
        end
        return dif[WORD_WIDTH-1:0];
    endfunction

    function automatic t_uword mag(t_word a);
        return a[WORD_WIDTH-1] ? t_uword'(-a) : t_uword'(a);
    endfunction

    function automatic t_word sat_mag(logic neg, logic [MAG_W-1:0] m);
        t_uword lo;
        lo = m[WORD_WIDTH-1:0];
        if (neg) begin
            if (m > LIM_NEG) return SMIN;
            return t_word'(-lo);
        end
        if (m > LIM_POS) return SMAX;
        return t_word'(lo);
    endfunction

    // round to nearest, ties away from zero, on the magnitude product
    function automatic t_word fx_round(logic neg, logic [2*WORD_WIDTH-1:0] p);
        logic [2*WORD_WIDTH:0] t;
        t = {1'b0, p} + RND_HALF;
        return sat_mag(neg, MAG_W'(t >> FRAC_BITS));
    endfunction

    function automatic t_uop mk(logic [SEL_W-1:0] a, logic [SEL_W-1:0] b,
                                logic [SEL_W-1:0] ld, logic [2:0] op,
                                logic [SEL_W-1:0] dst);
        t_uop u;
        u.mul_a  = a;
        u.mul_b  = b;
        u.ld_src = ld;
        u.acc_op = op;
        u.dst    = dst;
        return u;
    endfunction

    // one iteration: b terms, c terms, determinant and both numerators
    function automatic t_uop ucode(logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        case (pc)
            6'd0:  u = mk(SEL_ZERO, SEL_ZERO, SEL_A5, ACC_LD,   SEL_ZERO);
            6'd1:  u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_B5);
            6'd2:  u = mk(SEL_R,    SEL_B5,   SEL_A4, ACC_LD,   SEL_ZERO);
            6'd3:  u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd4:  u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_B4);
            6'd5:  u = mk(SEL_R,    SEL_B4,   SEL_A3, ACC_LD,   SEL_ZERO);
            6'd6:  u = mk(SEL_S,    SEL_B5,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd7:  u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd8:  u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_B3);
            6'd9:  u = mk(SEL_R,    SEL_B3,   SEL_A2, ACC_LD,   SEL_ZERO);
            6'd10: u = mk(SEL_S,    SEL_B4,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd11: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd12: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_B2);
            6'd13: u = mk(SEL_R,    SEL_B2,   SEL_A1, ACC_LD,   SEL_ZERO);
            6'd14: u = mk(SEL_S,    SEL_B3,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd15: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd16: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_B1);
            6'd17: u = mk(SEL_R,    SEL_B1,   SEL_A0, ACC_LD,   SEL_ZERO);
            6'd18: u = mk(SEL_S,    SEL_B2,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd19: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd20: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_B0);
            6'd21: u = mk(SEL_ZERO, SEL_ZERO, SEL_B5, ACC_LD,   SEL_ZERO);
            6'd22: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_C5);
            6'd23: u = mk(SEL_R,    SEL_C5,   SEL_B4, ACC_LD,   SEL_ZERO);
            6'd24: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd25: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_C4);
            6'd26: u = mk(SEL_R,    SEL_C4,   SEL_B3, ACC_LD,   SEL_ZERO);
            6'd27: u = mk(SEL_S,    SEL_C5,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd28: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd29: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_C3);
            6'd30: u = mk(SEL_R,    SEL_C3,   SEL_B2, ACC_LD,   SEL_ZERO);
            6'd31: u = mk(SEL_S,    SEL_C4,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd32: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd33: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_C2);
            6'd34: u = mk(SEL_R,    SEL_C2,   SEL_B1, ACC_LD,   SEL_ZERO);
            6'd35: u = mk(SEL_S,    SEL_C3,   SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd36: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_ADDP, SEL_ZERO);
            6'd37: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_C1);
            6'd38: u = mk(SEL_C2,   SEL_C2,   SEL_ZERO, ACC_NOP, SEL_ZERO);
            6'd39: u = mk(SEL_C3,   SEL_C1,   SEL_ZERO, ACC_LDP, SEL_ZERO);
            6'd40: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_SUBP, SEL_ZERO);
            6'd41: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_DET);
            6'd42: u = mk(SEL_B0,   SEL_C3,   SEL_ZERO, ACC_NOP, SEL_ZERO);
            6'd43: u = mk(SEL_B1,   SEL_C2,   SEL_ZERO, ACC_LDP, SEL_ZERO);
            6'd44: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_SUBP, SEL_ZERO);
            6'd45: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_NR);
            6'd46: u = mk(SEL_B1,   SEL_C1,   SEL_ZERO, ACC_NOP, SEL_ZERO);
            6'd47: u = mk(SEL_B0,   SEL_C2,   SEL_ZERO, ACC_LDP, SEL_ZERO);
            6'd48: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_SUBP, SEL_ZERO);
            6'd49: u = mk(SEL_ZERO, SEL_ZERO, SEL_ZERO, ACC_NOP, SEL_NS);
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

@@ rtl/bairstow_quadratic_factor_deg5_core.sv @@
// ----------------------------------------------------------------------------
// bairstow_quadratic_factor_deg5_core
// Quadratic factor refinement of a degree-5 polynomial in signed Q16.16.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  command  | i_start, o_busy              | i_initial_r, i_initial_s
//  result   | o_done (one-cycle strobe)    | o_final_r .. o_singular
//  config   | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Each iteration runs the microprogram through the shared multiplier, a
// determinant check, two 55-step serial divisions and an update. The percent
// errors take two more divisions. A singular stop skips the remaining
// iterations. Synchronous active-low reset returns the sequencer to idle and
// the registers to their defaults.
// The result strobe cannot be stalled; o_busy is high while an item is at work.
// ----------------------------------------------------------------------------
module bairstow_quadratic_factor_deg5_core
    import bqf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_word                 i_initial_r,
    input  t_word                 i_initial_s,
    output logic                  o_done,
    output t_word                 o_final_r,
    output t_word                 o_final_s,
    output t_word                 o_last_delta_r,
    output t_word                 o_last_delta_s,
    output t_uword                o_error_r_percent,
    output t_uword                o_error_s_percent,
    output logic [7:0]            o_iterations_done,
    output logic                  o_singular,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  t_uword                i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic busy;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = busy;

    bqf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bqf_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_initial_r       (i_initial_r),
        .i_initial_s       (i_initial_s),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_final_r         (o_final_r),
        .o_final_s         (o_final_s),
        .o_last_delta_r    (o_last_delta_r),
        .o_last_delta_s    (o_last_delta_s),
        .o_error_r_percent (o_error_r_percent),
        .o_error_s_percent (o_error_s_percent),
        .o_iterations_done (o_iterations_done),
        .o_singular        (o_singular)
    );

endmodule

@@ rtl/bqf_div.sv @@
// ----------------------------------------------------------------------------
// bqf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bqf_div
    import bqf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_W-1:0]      i_num,
    input  t_uword                i_den,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic                  r_run, r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIV_W-1:0]      r_num, r_q;
    t_uword                r_rem, r_den;
    logic [WORD_WIDTH:0]   rem_sh;
    logic                  ge;
    logic [WORD_WIDTH:0]   rem_sub;

    assign rem_sh  = {r_rem, r_num[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W-1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_run) begin
            r_num <= r_num << 1;
            r_rem <= ge ? rem_sub[WORD_WIDTH-1:0] : rem_sh[WORD_WIDTH-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/bqf_datapath.sv @@
// ----------------------------------------------------------------------------
// bqf_datapath
// Register file, configuration registers, shared multiplier with rounding
// accumulator, and the divider for corrections and percent errors.
// ----------------------------------------------------------------------------
module bqf_datapath
    import bqf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  t_uword                i_cfg_data,
    input  t_word                 i_initial_r,
    input  t_word                 i_initial_s,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_word                 o_final_r,
    output t_word                 o_final_s,
    output t_word                 o_last_delta_r,
    output t_word                 o_last_delta_s,
    output t_uword                o_error_r_percent,
    output t_uword                o_error_s_percent,
    output logic [7:0]            o_iterations_done,
    output logic                  o_singular
);

    t_word        r_coeff [0:5];
    logic [7:0]   r_iters;
    t_word        r_r, r_s, r_dr, r_ds, r_acc, r_det, r_nr, r_ns;
    t_word        r_b [0:5];
    t_word        r_c [1:5];
    t_uword       r_err_r, r_err_s;
    logic [7:0]   r_done;
    logic         r_sing;
    logic [2*WORD_WIDTH-1:0] r_pmag;
    logic         r_pneg;

    t_word        op_a, op_b, op_ld, prod_rnd;
    logic         div_done;
    logic [DIV_W-1:0] div_num, div_quot;
    t_uword       div_den;
    logic [WORD_WIDTH+PCT_W-1:0] pct_num;

    function automatic t_word sel_val(logic [SEL_W-1:0] sel);
        case (sel)
            SEL_R:   return r_r;
            SEL_S:   return r_s;
            SEL_B0:  return r_b[0];
            SEL_B1:  return r_b[1];
            SEL_B2:  return r_b[2];
            SEL_B3:  return r_b[3];
            SEL_B4:  return r_b[4];
            SEL_B5:  return r_b[5];
            SEL_C1:  return r_c[1];
            SEL_C2:  return r_c[2];
            SEL_C3:  return r_c[3];
            SEL_C4:  return r_c[4];
            SEL_C5:  return r_c[5];
            SEL_A0:  return r_coeff[0];
            SEL_A1:  return r_coeff[1];
            SEL_A2:  return r_coeff[2];
            SEL_A3:  return r_coeff[3];
            SEL_A4:  return r_coeff[4];
            SEL_A5:  return r_coeff[5];
            default: return '0;
        endcase
    endfunction

    assign op_a     = sel_val(i_cmd.uop.mul_a);
    assign op_b     = sel_val(i_cmd.uop.mul_b);
    assign op_ld    = sel_val(i_cmd.uop.ld_src);
    assign prod_rnd = fx_round(r_pneg, r_pmag);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_coeff[i] <= '0;
            r_iters <= ITERS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index <= REG_A5) begin
                r_coeff[i_cfg_index - REG_A0] <= t_word'(i_cfg_data);
            end else if (i_cfg_index == REG_ITERS) begin
                r_iters <= i_cfg_data[7:0];
            end
        end
    end

    // multiplier and accumulator
    always_ff @(posedge i_clk) begin
        r_pmag <= mag(op_a) * mag(op_b);
        r_pneg <= op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
        case (i_cmd.uop.acc_op)
            ACC_LD:   r_acc <= op_ld;
            ACC_LDP:  r_acc <= prod_rnd;
            ACC_ADDP: r_acc <= sat_add(r_acc, prod_rnd);
            ACC_SUBP: r_acc <= sat_sub(r_acc, prod_rnd);
            default:  r_acc <= r_acc;
        endcase
        case (i_cmd.uop.dst)
            SEL_B0:  r_b[0] <= r_acc;
            SEL_B1:  r_b[1] <= r_acc;
            SEL_B2:  r_b[2] <= r_acc;
            SEL_B3:  r_b[3] <= r_acc;
            SEL_B4:  r_b[4] <= r_acc;
            SEL_B5:  r_b[5] <= r_acc;
            SEL_C1:  r_c[1] <= r_acc;
            SEL_C2:  r_c[2] <= r_acc;
            SEL_C3:  r_c[3] <= r_acc;
            SEL_C4:  r_c[4] <= r_acc;
            SEL_C5:  r_c[5] <= r_acc;
            SEL_DET: r_det  <= r_acc;
            SEL_NR:  r_nr   <= r_acc;
            SEL_NS:  r_ns   <= r_acc;
            default: ;
        endcase
    end

    // divider operands
    always_comb begin
        pct_num = '0;
        div_num = '0;
        div_den = '0;
        case (i_cmd.div_kind)
            DK_DR: begin
                div_num = DIV_W'({mag(r_nr), {FRAC_BITS{1'b0}}});
                div_den = mag(r_det);
            end
            DK_DS: begin
                div_num = DIV_W'({mag(r_ns), {FRAC_BITS{1'b0}}});
                div_den = mag(r_det);
            end
            DK_PR: begin
                pct_num = (WORD_WIDTH+PCT_W)'(mag(r_dr)) * (WORD_WIDTH+PCT_W)'(PCT_SCALE);
                div_num = {pct_num, {FRAC_BITS{1'b0}}};
                div_den = mag(r_r);
            end
            DK_PS: begin
                pct_num = (WORD_WIDTH+PCT_W)'(mag(r_ds)) * (WORD_WIDTH+PCT_W)'(PCT_SCALE);
                div_num = {pct_num, {FRAC_BITS{1'b0}}};
                div_den = mag(r_s);
            end
            default: ;
        endcase
    end

    bqf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // iteration state and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_sing <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_r    <= i_initial_r;
                r_s    <= i_initial_s;
                r_dr   <= '0;
                r_ds   <= '0;
                r_done <= '0;
                r_sing <= 1'b0;
            end
            if (i_cmd.set_sing) r_sing <= 1'b1;
            if (i_cmd.update) begin
                r_r    <= sat_add(r_r, r_dr);
                r_s    <= sat_add(r_s, r_ds);
                r_done <= r_done + 8'd1;
            end
            if (i_cmd.div_store) begin
                case (i_cmd.div_kind)
                    DK_DR: r_dr <= sat_mag(r_nr[WORD_WIDTH-1] ^ r_det[WORD_WIDTH-1],
                                           MAG_W'(div_quot));
                    DK_DS: r_ds <= sat_mag(r_ns[WORD_WIDTH-1] ^ r_det[WORD_WIDTH-1],
                                           MAG_W'(div_quot));
                    DK_PR: r_err_r <= (div_quot > WMASK_D) ? '1 : div_quot[WORD_WIDTH-1:0];
                    DK_PS: r_err_s <= (div_quot > WMASK_D) ? '1 : div_quot[WORD_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.det_zero   = (r_det == '0);
    assign o_sts.iter_last  = (r_done == r_iters);
    assign o_sts.count_zero = (r_iters == 8'd0);
    assign o_sts.div_done   = div_done;

    assign o_final_r         = r_r;
    assign o_final_s         = r_s;
    assign o_last_delta_r    = r_dr;
    assign o_last_delta_s    = r_ds;
    assign o_error_r_percent = r_err_r;
    assign o_error_s_percent = r_err_s;
    assign o_iterations_done = r_done;
    assign o_singular        = r_sing;

endmodule

@@ rtl/bqf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bqf_ctrl
// Sequencer: steps the microprogram, runs the divisions, counts iterations
// and strobes the result.
// ----------------------------------------------------------------------------
module bqf_ctrl
    import bqf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_sts  i_sts,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RUN  = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_DR   = 4'd3;
    localparam logic [3:0] ST_DRW  = 4'd4;
    localparam logic [3:0] ST_DS   = 4'd5;
    localparam logic [3:0] ST_DSW  = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_CNT  = 4'd8;
    localparam logic [3:0] ST_PR   = 4'd9;
    localparam logic [3:0] ST_PRW  = 4'd10;
    localparam logic [3:0] ST_PS   = 4'd11;
    localparam logic [3:0] ST_PSW  = 4'd12;

    logic [3:0]      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_strobe, n_strobe;

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_strobe = 1'b0;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    n_pc          = '0;
                    n_state       = i_sts.count_zero ? ST_PR : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.uop = ucode(r_pc);
                n_pc      = r_pc + PC_W'(1);
                if (r_pc == PC_W'(UC_LEN-1)) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (i_sts.det_zero) begin
                    o_cmd.set_sing = 1'b1;
                    n_state        = ST_PR;
                end else begin
                    n_state = ST_DR;
                end
            end
            ST_DR: begin
                o_cmd.div_kind  = DK_DR;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DRW;
            end
            ST_DRW: begin
                o_cmd.div_kind = DK_DR;
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = ST_DS;
                end
            end
            ST_DS: begin
                o_cmd.div_kind  = DK_DS;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DSW;
            end
            ST_DSW: begin
                o_cmd.div_kind = DK_DS;
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_CNT;
            end
            ST_CNT: begin
                n_pc    = '0;
                n_state = i_sts.iter_last ? ST_PR : ST_RUN;
            end
            ST_PR: begin
                o_cmd.div_kind  = DK_PR;
                o_cmd.div_start = 1'b1;
                n_state         = ST_PRW;
            end
            ST_PRW: begin
                o_cmd.div_kind = DK_PR;
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = ST_PS;
                end
            end
            ST_PS: begin
                o_cmd.div_kind  = DK_PS;
                o_cmd.div_start = 1'b1;
                n_state         = ST_PSW;
            end
            ST_PSW: begin
                o_cmd.div_kind = DK_PS;
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_strobe        = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_strobe;

endmodule
